[hdl/kcalc_pkg.sv]
// ----------------------------------------------------------------------------
// kcalc_pkg
// shared types, key codes and controller/datapath interface for the
// keypad four-function calculator
// ----------------------------------------------------------------------------
`default_nettype none

package kcalc_pkg;

  // default operand width
  localparam int unsigned DEF_WIDTH = 32;

  // key codes
  localparam logic [7:0] KEY_NONE  = 8'h41;  // 'A'
  localparam logic [7:0] KEY_CLEAR = 8'h3F;  // '?'
  localparam logic [7:0] KEY_EQ    = 8'h3D;  // '='
  localparam logic [7:0] KEY_MUL   = 8'h2A;  // '*'
  localparam logic [7:0] KEY_DIV   = 8'h2F;  // '/'
  localparam logic [7:0] KEY_ADD   = 8'h2B;  // '+'
  localparam logic [7:0] KEY_SUB   = 8'h2D;  // '-'
  localparam logic [8:0] DIGIT_BASE = 9'd48;

  // output word layout
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned OUT_USER_W = 2;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_MUL  = 3'd1,
    OP_DIV  = 3'd2,
    OP_ADD  = 3'd3,
    OP_SUB  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_VALUE    = 2'd1,
    KIND_DIV_ZERO = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ITER,
    ST_FINISH,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic capture;  // take key word
    logic decode;   // apply key, form immediate result, arm iteration
    logic step;     // one multiply / divide iteration
    logic finish;   // fold iteration result into pending result
    logic emit;     // move pending result into output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_iter;  // evaluate needs the shared multiply/divide loop
    logic iter_last;  // final iteration in progress
    logic out_free;   // output register empty or being drained
  } ctrl_sts_t;

endpackage

`default_nettype wire

[hdl/kcalc_ctrl.sv]
// ----------------------------------------------------------------------------
// kcalc_ctrl
// sequencing state machine: capture, decode, iterate, finish, emit
// ----------------------------------------------------------------------------
`default_nettype none

module kcalc_ctrl
  import kcalc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire ctrl_sts_t sts_i,
  output ctrl_cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        state_d = sts_i.need_iter ? ST_ITER : ST_EMIT;
      end
      ST_ITER: begin
        if (sts_i.iter_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
      end
      ST_ITER: begin
        cmd_o.step = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/kcalc_dp.sv]
// ----------------------------------------------------------------------------
// kcalc_dp
// operand registers, digit accumulation, shared shift-add multiply and
// restoring divide loop, output register
// ----------------------------------------------------------------------------
`default_nettype none

module kcalc_dp
  import kcalc_pkg::*;
#(
  parameter int unsigned WIDTH = DEF_WIDTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ctrl_cmd_t             cmd_i,
  output ctrl_sts_t                  sts_o,
  input  wire logic [7:0]            key_code_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       echo_valid_o,
  output logic [7:0]                 echo_char_o,
  output logic                       clear_display_o,
  output logic [OUT_USER_W-1:0]      result_kind_o,
  output logic signed [VAL_W-1:0]    result_value_o
);

  localparam int unsigned CNT_W = $clog2(WIDTH);

  // architectural state
  logic [WIDTH-1:0] op_a_q, op_a_d;
  logic [WIDTH-1:0] op_b_q, op_b_d;
  op_e              opr_q, opr_d;
  logic             sec_q, sec_d;

  logic [7:0] key_q;

  // pending result
  logic             res_echo_q, res_echo_d;
  logic             res_clr_q, res_clr_d;
  kind_e            res_kind_q, res_kind_d;
  logic [WIDTH-1:0] res_val_q, res_val_d;

  // iteration registers
  logic [WIDTH-1:0] acc_q, mcand_q, sh_q;
  logic [CNT_W-1:0] cnt_q;
  logic             it_div_q, it_neg_q;

  // output register
  logic                   out_valid_q;
  logic                   out_echo_q, out_clr_q;
  logic [7:0]             out_char_q;
  logic [OUT_USER_W-1:0]  out_kind_q;
  logic [VAL_W-1:0]       out_val_q;

  logic             is_op;
  logic             need_iter;
  op_e              key_op;
  logic [8:0]       digit9;
  logic [WIDTH+8:0] digit_x;
  logic [WIDTH-1:0] acc_sel, acc_new;
  logic [WIDTH-1:0] abs_a, abs_b;
  logic [WIDTH:0]   trial;
  logic [WIDTH-1:0] quot;
  logic [WIDTH+31:0] val_x;

  assign is_op = (key_q inside {KEY_MUL, KEY_DIV, KEY_ADD, KEY_SUB});

  always_comb begin
    case (key_q)
      KEY_MUL: key_op = OP_MUL;
      KEY_DIV: key_op = OP_DIV;
      KEY_ADD: key_op = OP_ADD;
      KEY_SUB: key_op = OP_SUB;
      default: key_op = OP_NONE;
    endcase
  end

  // signed digit weight, sign extended to the operand width
  assign digit9  = {1'b0, key_q} - DIGIT_BASE;
  assign digit_x = {{WIDTH{digit9[8]}}, digit9};
  assign acc_sel = sec_q ? op_b_q : op_a_q;
  assign acc_new = (acc_sel << 3) + (acc_sel << 1) + digit_x[WIDTH-1:0];

  assign abs_a = op_a_q[WIDTH-1] ? (~op_a_q + 1'b1) : op_a_q;
  assign abs_b = op_b_q[WIDTH-1] ? (~op_b_q + 1'b1) : op_b_q;

  assign need_iter = (key_q == KEY_EQ) &&
                     ((opr_q == OP_MUL) || ((opr_q == OP_DIV) && (op_b_q != '0)));

  always_comb begin
    op_a_d     = op_a_q;
    op_b_d     = op_b_q;
    opr_d      = opr_q;
    sec_d      = sec_q;
    res_echo_d = res_echo_q;
    res_clr_d  = res_clr_q;
    res_kind_d = res_kind_q;
    res_val_d  = res_val_q;
    if (cmd_i.decode) begin
      res_echo_d = 1'b0;
      res_clr_d  = 1'b0;
      res_kind_d = KIND_NONE;
      res_val_d  = '0;
      if (key_q == KEY_NONE) begin
        // idle key
      end else if (key_q == KEY_CLEAR) begin
        op_a_d    = '0;
        op_b_d    = '0;
        sec_d     = 1'b0;
        res_clr_d = 1'b1;
      end else if (key_q == KEY_EQ) begin
        res_echo_d = 1'b1;
        case (opr_q)
          OP_MUL: res_kind_d = KIND_VALUE;
          OP_ADD: begin
            res_kind_d = KIND_VALUE;
            res_val_d  = op_a_q + op_b_q;
          end
          OP_SUB: begin
            res_kind_d = KIND_VALUE;
            res_val_d  = op_a_q - op_b_q;
          end
          OP_DIV: begin
            if (op_b_q == '0) begin
              res_kind_d = KIND_DIV_ZERO;
              res_clr_d  = 1'b1;
            end else begin
              res_kind_d = KIND_VALUE;
            end
          end
          default: res_kind_d = KIND_NONE;
        endcase
      end else if (is_op) begin
        res_echo_d = 1'b1;
        opr_d      = key_op;
        sec_d      = 1'b1;
      end else begin
        res_echo_d = 1'b1;
        if (sec_q) begin
          op_b_d = acc_new;
        end else begin
          op_a_d = acc_new;
        end
      end
    end else if (cmd_i.finish) begin
      res_val_d = it_div_q ? quot : acc_q;
    end
  end

  // restoring divide trial subtract
  assign trial = {acc_q, sh_q[WIDTH-1]} - {1'b0, mcand_q};
  assign quot  = it_neg_q ? (~sh_q + 1'b1) : sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_a_q <= '0;
      op_b_q <= '0;
      opr_q  <= OP_NONE;
      sec_q  <= 1'b0;
    end else begin
      op_a_q <= op_a_d;
      op_b_q <= op_b_d;
      opr_q  <= opr_d;
      sec_q  <= sec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) key_q <= key_code_i;
    res_echo_q <= res_echo_d;
    res_clr_q  <= res_clr_d;
    res_kind_q <= res_kind_d;
    res_val_q  <= res_val_d;
  end

  // shared iteration loop
  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      acc_q    <= '0;
      cnt_q    <= '0;
      it_div_q <= (opr_q == OP_DIV);
      it_neg_q <= op_a_q[WIDTH-1] ^ op_b_q[WIDTH-1];
      if (opr_q == OP_DIV) begin
        mcand_q <= abs_b;
        sh_q    <= abs_a;
      end else begin
        mcand_q <= op_a_q;
        sh_q    <= op_b_q;
      end
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + 1'b1;
      if (it_div_q) begin
        if (!trial[WIDTH]) begin
          acc_q <= trial[WIDTH-1:0];
        end else begin
          acc_q <= {acc_q[WIDTH-2:0], sh_q[WIDTH-1]};
        end
        sh_q <= {sh_q[WIDTH-2:0], ~trial[WIDTH]};
      end else begin
        if (sh_q[0]) acc_q <= acc_q + mcand_q;
        mcand_q <= mcand_q << 1;
        sh_q    <= sh_q >> 1;
      end
    end
  end

  // output register
  assign val_x = {{VAL_W{1'b0}}, res_val_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_echo_q <= res_echo_q;
      out_char_q <= res_echo_q ? key_q : 8'h00;
      out_clr_q  <= res_clr_q;
      out_kind_q <= res_kind_q;
      out_val_q  <= val_x[VAL_W-1:0];
    end
  end

  assign sts_o.need_iter = need_iter;
  assign sts_o.iter_last = (cnt_q == CNT_W'(WIDTH - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign echo_valid_o    = out_echo_q;
  assign echo_char_o     = out_char_q;
  assign clear_display_o = out_clr_q;
  assign result_kind_o   = out_kind_q;
  assign result_value_o  = out_val_q;

endmodule

`default_nettype wire

[hdl/keypad_four_function_calculator.sv]
// a key word is captured, decoded into a pending result, then moved into the
//   output register; an evaluate with multiply or nonzero divide also passes
//   the iterate and finish states, using the shared one-bit-per-cycle
//   shift-add / restoring-divide loop; the next key is taken only when idle
// the output register holds a finished word while the next key is taken
// reset (rst_ni low, asynchronous): operands zero, no operator, no word pending
// ----------------------------------------------------------------------------
// keypad_four_function_calculator
// four-function calculator core fed by ascii key words, giving one result
// word per key with echo, display clear and computed value
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_four_function_calculator
  import kcalc_pkg::*;
#(
  parameter int unsigned WIDTH = DEF_WIDTH  // operand width, 8 to 64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // key input
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,   // [7:0] key_code
  // result output
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_DATA_W-1:0]       m_axis_tdata,   // [0] echo_valid, [8:1] echo_char,
                                                      // [9] clear_display,
                                                      // [41:10] result_value, rest zero
  output logic [OUT_USER_W-1:0]       m_axis_tuser    // [1:0] result_kind
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  logic                     echo_valid;
  logic [7:0]               echo_char;
  logic                     clear_display;
  logic signed [VAL_W-1:0]  result_value;

  // sequencer: one key at a time, iterates for multiply and nonzero divide
  kcalc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // operands, arithmetic loop and output register
  kcalc_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .key_code_i      (s_axis_tdata),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .echo_valid_o    (echo_valid),
    .echo_char_o     (echo_char),
    .clear_display_o (clear_display),
    .result_kind_o   (m_axis_tuser),
    .result_value_o  (result_value)
  );

  // pack result word, low field first, padded to whole bytes
  assign m_axis_tdata = {6'b0, result_value, clear_display, echo_char, echo_valid};

endmodule

`default_nettype wire

[hdl/kcalc_chk.sv]
// ----------------------------------------------------------------------------
// kcalc_chk
// port-level checks on the calculator result stream
// ----------------------------------------------------------------------------
`default_nettype none

module kcalc_chk
  import kcalc_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [OUT_USER_W-1:0] m_axis_tuser
);

  // stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // divide by zero always asks for a display clear and comes with an echo
  a_dz_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_DIV_ZERO) |-> m_axis_tdata[9] && m_axis_tdata[0])
    else $error("divide by zero without clear");

  // value is zero unless a numeric result is reported
  a_val_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_VALUE) |-> m_axis_tdata[41:10] == '0)
    else $error("stray result value");

  // no echo means echo char is zero and no result kind is reported
  a_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |->
      (m_axis_tdata[8:1] == 8'h00) && (m_axis_tuser == KIND_NONE))
    else $error("echo fields inconsistent");

endmodule

bind keypad_four_function_calculator kcalc_chk u_kcalc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
